[rtl/rgbls_pkg.sv]
`timescale 1ns / 1ps

package rgbls_pkg;

  localparam int DATA_W = 8;
  localparam int REG_IDX_W = 3;
  localparam int OP_W = 2;
  localparam int COLOUR_W = 3;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam int COL_RED = 0;
  localparam int COL_GREEN = 1;
  localparam int COL_BLUE = 2;

  localparam logic [DATA_W-1:0] WALK_TOP = 8'h80;
  localparam logic [DATA_W-1:0] WALK_ODD_SKIP = 8'h10;
  localparam logic [DATA_W-1:0] WALK_NONE = 8'h00;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [REG_IDX_W-1:0] register_index;
    logic [DATA_W-1:0] bit_mask;
    logic [COLOUR_W-1:0] colour_set;
    logic [COLOUR_W-1:0] five_colour_set;
  } in_word_t;

  typedef struct packed {
    logic shift_valid;
    logic [DATA_W-1:0] shift_byte;
    logic latch_pulse;
    logic red_off;
    logic green_off;
    logic blue_off;
  } out_word_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0] red_bits;
    logic [DATA_W-1:0] green_bits;
    logic [DATA_W-1:0] blue_bits;
  } map_upd_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } colour_off_t;

endpackage

[rtl/rgbls_channels.sv]
`timescale 1ns / 1ps

interface rgbls_in_if;
  logic valid;
  logic ready;
  rgbls_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgbls_out_if;
  logic valid;
  logic ready;
  rgbls_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgbls_cfg_if;
  logic valid;
  logic ready;
  logic [rgbls_pkg::DATA_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rgbls_maps.sv]
`timescale 1ns / 1ps

module rgbls_maps #(
  parameter int CHAIN_LENGTH = 6
) (
  input  logic clk,
  input  logic rst,
  input  rgbls_pkg::map_upd_t upd,
  input  logic [$clog2(CHAIN_LENGTH+1)-1:0] sel,
  input  logic [rgbls_pkg::DATA_W-1:0] walk,
  output rgbls_pkg::colour_off_t off
);

  localparam int CW = $clog2(CHAIN_LENGTH + 1);

  logic [rgbls_pkg::DATA_W-1:0] red_map [CHAIN_LENGTH];
  logic [rgbls_pkg::DATA_W-1:0] green_map [CHAIN_LENGTH];
  logic [rgbls_pkg::DATA_W-1:0] blue_map [CHAIN_LENGTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      if (rst) begin
        red_map[i] <= '0;
        green_map[i] <= '0;
        blue_map[i] <= '0;
      end else if (upd.en && upd.idx == rgbls_pkg::REG_IDX_W'(i)) begin
        if (upd.clr) begin
          red_map[i] <= red_map[i] & ~upd.red_bits;
          green_map[i] <= green_map[i] & ~upd.green_bits;
          blue_map[i] <= blue_map[i] & ~upd.blue_bits;
        end else begin
          red_map[i] <= red_map[i] | upd.red_bits;
          green_map[i] <= green_map[i] | upd.green_bits;
          blue_map[i] <= blue_map[i] | upd.blue_bits;
        end
      end
    end
  end

  // past the last register every colour reads as off
  always_comb begin
    off = '1;
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      if (sel == CW'(i)) begin
        off.red = ~|(red_map[i] & walk);
        off.green = ~|(green_map[i] & walk);
        off.blue = ~|(blue_map[i] & walk);
      end
    end
  end

endmodule

[rtl/rgb_led_matrix_scan_sequencer.sv]
`timescale 1ns / 1ps

// channel  dir  word               handshake
// req      in   in_word_t          valid/ready
// rsp      out  out_word_t         valid/ready
// cfg      in   five_mask, 8 bits  valid/ready, always ready
//
// one word in per cycle while rsp is not stalled; each result passes the input reg, then the result reg
// every word gives exactly one result word
// rst is synchronous: bitmaps, scan counters and five_mask clear
// a stalled rsp holds the result; req keeps taking words until the input reg fills

module rgb_led_matrix_scan_sequencer #(
  parameter int CHAIN_LENGTH = 6
) (
  input logic clk,
  input logic rst,
  rgbls_in_if.sink req,
  rgbls_out_if.source rsp,
  rgbls_cfg_if.sink cfg
);

  localparam int CW = $clog2(CHAIN_LENGTH + 1);
  localparam int DW = rgbls_pkg::DATA_W;

  logic [DW-1:0] five_mask;
  logic s1_valid;
  rgbls_pkg::in_word_t s1;
  logic s1_adv;
  logic out_valid;
  rgbls_pkg::out_word_t out_word;

  logic [DW-1:0] walking_bit, walking_bit_next;
  logic [CW-1:0] selected_register, selected_register_next;
  logic [CW-1:0] byte_count, byte_count_next;

  logic tick, latch, hit;
  logic [CW-1:0] bc_eff, sel_wrap;
  logic [DW-1:0] walk_adv;
  logic five_hit;
  logic [DW-1:0] rest;
  rgbls_pkg::map_upd_t upd;
  rgbls_pkg::colour_off_t off;
  rgbls_pkg::out_word_t res;

  assign cfg.ready = 1'b1;
  assign s1_adv = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign rsp.valid = out_valid;
  assign rsp.data = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      five_mask <= '0;
    end else if (cfg.valid && cfg.ready) begin
      five_mask <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
  end

  // scan step
  always_comb begin
    tick = s1.opcode == rgbls_pkg::OP_TICK;
    latch = tick && (byte_count >= CW'(CHAIN_LENGTH));
    bc_eff = latch ? '0 : byte_count;
    sel_wrap = (selected_register >= CW'(CHAIN_LENGTH)) ? '0 : selected_register;
    hit = bc_eff == sel_wrap;
    if (walking_bit == rgbls_pkg::WALK_NONE) begin
      walk_adv = 8'h01;
    end else if (walking_bit == rgbls_pkg::WALK_TOP) begin
      walk_adv = rgbls_pkg::WALK_NONE;
    end else if (sel_wrap[0] && walking_bit == rgbls_pkg::WALK_ODD_SKIP) begin
      walk_adv = rgbls_pkg::WALK_TOP;
    end else begin
      walk_adv = walking_bit << 1;
    end
    byte_count_next = bc_eff + CW'(1);
    walking_bit_next = hit ? walk_adv : walking_bit;
    selected_register_next = (hit && walking_bit == rgbls_pkg::WALK_TOP) ?
                             sel_wrap + CW'(1) : sel_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking_bit <= '0;
      selected_register <= '0;
      byte_count <= '0;
    end else if (s1_adv && tick) begin
      walking_bit <= walking_bit_next;
      selected_register <= selected_register_next;
      byte_count <= byte_count_next;
    end
  end

  // bitmap update masks
  always_comb begin
    five_hit = (s1.five_colour_set != '0) && (s1.bit_mask == five_mask);
    rest = s1.bit_mask & ~five_mask;
    upd.en = s1_adv && (s1.opcode == rgbls_pkg::OP_SET || s1.opcode == rgbls_pkg::OP_CLEAR);
    upd.clr = s1.opcode == rgbls_pkg::OP_CLEAR;
    upd.idx = s1.register_index;
    if (s1.opcode == rgbls_pkg::OP_SET && five_hit) begin
      upd.red_bits = (s1.five_colour_set[rgbls_pkg::COL_RED] ? five_mask : '0) |
                     (s1.colour_set[rgbls_pkg::COL_RED] ? rest : '0);
      upd.green_bits = (s1.five_colour_set[rgbls_pkg::COL_GREEN] ? five_mask : '0) |
                       (s1.colour_set[rgbls_pkg::COL_GREEN] ? rest : '0);
      upd.blue_bits = (s1.five_colour_set[rgbls_pkg::COL_BLUE] ? five_mask : '0) |
                      (s1.colour_set[rgbls_pkg::COL_BLUE] ? rest : '0);
    end else begin
      upd.red_bits = s1.colour_set[rgbls_pkg::COL_RED] ? s1.bit_mask : '0;
      upd.green_bits = s1.colour_set[rgbls_pkg::COL_GREEN] ? s1.bit_mask : '0;
      upd.blue_bits = s1.colour_set[rgbls_pkg::COL_BLUE] ? s1.bit_mask : '0;
    end
  end

  rgbls_maps #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_maps (
    .clk(clk),
    .rst(rst),
    .upd(upd),
    .sel(selected_register),
    .walk(walking_bit),
    .off(off)
  );

  always_comb begin
    res = '0;
    if (tick) begin
      res.shift_valid = 1'b1;
      res.shift_byte = hit ? walk_adv : rgbls_pkg::WALK_NONE;
      res.latch_pulse = latch;
      res.red_off = latch && off.red;
      res.green_off = latch && off.green;
      res.blue_off = latch && off.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
    if (s1_adv) begin
      out_word <= res;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(CHAIN_LENGTH) && selected_register <= CW'(CHAIN_LENGTH))
    else $error("scan counter out of range");

  a_byte_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_word.shift_byte))
    else $error("shift byte not one-hot");

  a_non_tick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.shift_valid |-> out_word == '0)
    else $error("non-tick word with nonzero result");

  a_off_needs_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.latch_pulse |->
      !out_word.red_off && !out_word.green_off && !out_word.blue_off)
    else $error("colour level without latch");

  a_latch_restart: assert property (@(posedge clk) disable iff (rst)
    s1_adv && latch |=> byte_count == CW'(1))
    else $error("latch did not restart byte count");

endmodule
